/* src/sssp_pkg.sv */
// package: constants and types for the shortest path block
`timescale 1ns / 1ps
package sssp_pkg;
	localparam int MaxNodes = 64;
	localparam int MaxArcs = 256;
	localparam int NodeW = $clog2(MaxNodes);
	localparam int ArcW = $clog2(MaxArcs);
	localparam int DistW = 15;
	localparam int NcW = $clog2(MaxNodes + 1);
	localparam int AcW = $clog2(MaxArcs + 1);
	localparam logic [DistW-1:0] DistSat = 15'd32767;
	localparam logic [1:0] RegNodeCount = 2'd0;
	localparam logic [1:0] RegArcCount = 2'd1;
	localparam logic ActLoad = 1'b0;
	localparam logic ActRun = 1'b1;

	typedef struct packed {
		logic             vld;
		logic [NodeW-1:0] from;
		logic [NodeW-1:0] to;
		logic [DistW-1:0] weight;
	} arc_t;

	typedef struct packed {
		logic             found;
		logic [DistW:0]   best;
		logic [NodeW-1:0] best_to;
	} best_t;
endpackage

/* src/sssp_cell.sv */
// node cell: holds one node's distance and visited flag, forwards arc words
`timescale 1ns / 1ps
module sssp_cell import sssp_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [NodeW-1:0] node_id,
	input  logic             clr,
	input  logic             seed,
	input  logic             commit,
	input  logic [NodeW-1:0] commit_to,
	input  logic [DistW-1:0] commit_dist,
	input  arc_t             arc_in,
	output arc_t             arc_out,
	input  logic [DistW:0]   sum_in,
	output logic [DistW:0]   sum_out,
	input  logic             ok_in,
	output logic             ok_out,
	output logic [DistW-1:0] node_dist
);
	logic [DistW-1:0] dist_q;
	logic             vis_q;
	logic             ok_d;
	logic [DistW:0]   sum_d;

	always_comb begin
		ok_d = ok_in;
		sum_d = sum_in;
		if (arc_in.from == node_id) begin
			ok_d = ok_d & vis_q;
			sum_d = {1'b0, dist_q} + {1'b0, arc_in.weight};
		end
		if (arc_in.to == node_id) ok_d = ok_d & ~vis_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dist_q <= DistSat;
			vis_q <= 1'b0;
		end else if (clr) begin
			dist_q <= seed ? '0 : DistSat;
			vis_q <= seed;
		end else if (commit && commit_to == node_id) begin
			dist_q <= commit_dist;
			vis_q <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			arc_out <= '0;
			sum_out <= '0;
			ok_out <= 1'b0;
		end else begin
			arc_out <= arc_in;
			sum_out <= sum_d;
			ok_out <= ok_d;
		end
	end

	assign node_dist = dist_q;
endmodule

/* src/single_source_shortest_path.sv */
// top level: arc store, node cell chain and round sequencer
`timescale 1ns / 1ps
// A load word writes one arc slot of the arc store. A run word takes up to node_count
// rounds; each round streams arc_count arcs from the arc store through a chain of
// MaxNodes node cells (one cell a cycle) and picks the best arc at the chain end.
module single_source_shortest_path import sssp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [8:0]  cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	// action, arc_slot, arc_source, arc_target, arc_weight, origin, destination
	input  logic [47:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// distance, reachable
	output logic [15:0] m_tdata
);
	typedef enum logic [3:0] {
		S_IDLE = 4'b0001, S_SCAN = 4'b0010, S_DRAIN = 4'b0100, S_OUT = 4'b1000
	} state_t;

	state_t state_q;
	logic [NcW-1:0] nc_q;
	logic [AcW-1:0] ac_q;
	logic [NodeW-1:0] dst_q;
	logic [NcW-1:0] nc_eff;
	logic [AcW-1:0] ac_eff;
	logic [AcW-1:0] rd_q;
	logic [7:0] drain_q;
	logic rd_vld_s1;
	logic [NodeW-1:0] from_s1;
	logic [NodeW-1:0] to_s1;
	logic [DistW-1:0] w_s1;
	logic [NodeW-1:0] from_mem [MaxArcs];
	logic [NodeW-1:0] to_mem [MaxArcs];
	logic [DistW-1:0] w_mem [MaxArcs];
	best_t best_q;
	logic clr, commit;
	logic [DistW-1:0] commit_dist;
	logic [DistW-1:0] res_dist_q;
	logic res_reach_q;

	arc_t arc_c [MaxNodes+1];
	logic [DistW:0] sum_c [MaxNodes+1];
	logic ok_c [MaxNodes+1];
	logic [DistW-1:0] dist_c [MaxNodes];

	logic in_act;
	logic [ArcW-1:0] in_slot;
	logic in_acc;
	assign in_act = s_tdata[0];
	assign in_slot = s_tdata[8:1];
	assign s_tready = (state_q == S_IDLE);
	assign in_acc = s_tvalid & s_tready;
	assign nc_eff = (nc_q > NcW'(MaxNodes)) ? NcW'(MaxNodes) : nc_q;
	assign ac_eff = (ac_q > AcW'(MaxArcs)) ? AcW'(MaxArcs) : ac_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nc_q <= NcW'(MaxNodes);
			ac_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				RegNodeCount: nc_q <= cfg_data[NcW-1:0];
				RegArcCount: ac_q <= cfg_data[AcW-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && in_act == ActLoad) begin
			from_mem[in_slot] <= s_tdata[14:9];
			to_mem[in_slot] <= s_tdata[20:15];
			w_mem[in_slot] <= s_tdata[35:21];
		end
		from_s1 <= from_mem[rd_q[ArcW-1:0]];
		to_s1 <= to_mem[rd_q[ArcW-1:0]];
		w_s1 <= w_mem[rd_q[ArcW-1:0]];
	end

	always_comb begin
		arc_c[0].vld = rd_vld_s1 & ({1'b0, from_s1} < nc_eff)
			& ({1'b0, to_s1} < nc_eff);
		arc_c[0].from = from_s1;
		arc_c[0].to = to_s1;
		arc_c[0].weight = w_s1;
		sum_c[0] = '0;
		ok_c[0] = 1'b1;
	end

	assign clr = in_acc && in_act == ActRun;

	for (genvar i = 0; i < MaxNodes; i++) begin : g_cell
		sssp_cell u_cell (
			.clk(clk), .arst_n(arst_n), .node_id(NodeW'(i)), .clr(clr),
			.seed(s_tdata[41:36] == NodeW'(i) && (NcW'(i) < nc_eff)),
			.commit(commit), .commit_to(best_q.best_to), .commit_dist(commit_dist),
			.arc_in(arc_c[i]), .arc_out(arc_c[i+1]),
			.sum_in(sum_c[i]), .sum_out(sum_c[i+1]),
			.ok_in(ok_c[i]), .ok_out(ok_c[i+1]),
			.node_dist(dist_c[i])
		);
	end

	logic take;
	assign take = arc_c[MaxNodes].vld & ok_c[MaxNodes]
		& (~best_q.found | (sum_c[MaxNodes] < best_q.best));
	assign commit_dist = best_q.best[DistW] ? DistSat : best_q.best[DistW-1:0];
	assign commit = (state_q == S_DRAIN) && (drain_q == 8'(MaxNodes + 1)) && best_q.found;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			dst_q <= '0;
			rd_q <= '0;
			rd_vld_s1 <= 1'b0;
			drain_q <= '0;
			best_q <= '0;
			m_tvalid <= 1'b0;
		end else begin
			rd_vld_s1 <= (state_q == S_SCAN) && (rd_q < ac_eff);
			if (m_tvalid && m_tready) m_tvalid <= 1'b0;
			case (state_q)
				S_IDLE: if (clr) begin
					dst_q <= s_tdata[47:42];
					rd_q <= '0;
					best_q <= '0;
					state_q <= S_SCAN;
				end
				S_SCAN: begin
					if (take) best_q <= '{1'b1, sum_c[MaxNodes], arc_c[MaxNodes].to};
					if (rd_q < ac_eff) rd_q <= rd_q + 1'b1;
					else begin
						drain_q <= '0;
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					if (take && drain_q <= 8'(MaxNodes))
						best_q <= '{1'b1, sum_c[MaxNodes], arc_c[MaxNodes].to};
					if (drain_q == 8'(MaxNodes + 1)) begin
						if (best_q.found) begin
							best_q <= '0;
							rd_q <= '0;
							state_q <= S_SCAN;
						end else begin
							state_q <= S_OUT;
						end
					end else drain_q <= drain_q + 1'b1;
				end
				S_OUT: if (!m_tvalid) begin
					m_tvalid <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_OUT && !m_tvalid) begin
			res_dist_q <= ({1'b0, dst_q} < nc_eff) ? dist_c[dst_q] : DistSat;
			res_reach_q <= ({1'b0, dst_q} < nc_eff) && (dist_c[dst_q] != DistSat);
		end
	end
	assign m_tdata = {res_reach_q, res_dist_q};

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result word changed while waiting");
	a_commit_scan: assert property (@(posedge clk) disable iff (!arst_n)
		commit |=> state_q == S_SCAN) else $error("commit must start a round");
	a_out_once: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state_q == S_OUT)) else $error("stray result");
endmodule
